// ===== rtl/core/pip_pkg.sv =====
// ---------------------------------------------------------------------------
// Point-in-polygon package
// Field widths and item kind codes shared by the channels and the core.
// ---------------------------------------------------------------------------
`default_nettype none

package pip_pkg;

   localparam int KIND_W  = 2;
   localparam int COUNT_W = 7;

   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TEST   = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/core/pip_if.sv =====
// ---------------------------------------------------------------------------
// Point-in-polygon channels
// Request and response interfaces with valid/ready handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

interface pip_req_if #(parameter int COORD_BITS = 20);
   import pip_pkg::*;
   logic                         valid;
   logic                         ready;
   logic [KIND_W-1:0]            kind;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;

   modport source (output valid, kind, coord_x, coord_y, input ready);
   modport sink   (input valid, kind, coord_x, coord_y, output ready);
endinterface

interface pip_rsp_if;
   import pip_pkg::*;
   logic               valid;
   logic               ready;
   logic               inside_res;
   logic [COUNT_W-1:0] crossing_count;
   logic               table_overflowed;

   modport source (output valid, inside_res, crossing_count, table_overflowed,
                   input ready);
   modport sink   (input valid, inside_res, crossing_count, table_overflowed,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/pip_cell.sv =====
// ---------------------------------------------------------------------------
// Vertex cell
// Holds one polygon vertex; loads on append and takes its neighbour's
// vertex on every rotation step of a test.
// ---------------------------------------------------------------------------
`default_nettype none

module pip_cell #(
   parameter int DW = 20
) (
   input  wire logic                 clock,
   input  wire logic                 load_en,
   input  wire logic signed [DW-1:0] load_x,
   input  wire logic signed [DW-1:0] load_y,
   input  wire logic                 shift_en,
   input  wire logic signed [DW-1:0] next_x,
   input  wire logic signed [DW-1:0] next_y,
   output logic signed [DW-1:0]      cell_x,
   output logic signed [DW-1:0]      cell_y
);

   logic signed [DW-1:0] x_ff, y_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         x_ff <= load_x;
         y_ff <= load_y;
      end else if (shift_en) begin
         x_ff <= next_x;
         y_ff <= next_y;
      end
   end

   assign cell_x = x_ff;
   assign cell_y = y_ff;

endmodule

`default_nettype wire

// ===== rtl/core/pip_edge.sv =====
// ---------------------------------------------------------------------------
// Edge crossing unit
// Three-stage pipeline deciding whether the rightward ray from the query
// point crosses one edge, using an exact cross-multiplied comparison.
// ---------------------------------------------------------------------------
`default_nettype none

module pip_edge #(
   parameter int DW = 20
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire logic signed [DW-1:0] px,
   input  wire logic signed [DW-1:0] py,
   input  wire logic signed [DW-1:0] xi,
   input  wire logic signed [DW-1:0] yi,
   input  wire logic signed [DW-1:0] xj,
   input  wire logic signed [DW-1:0] yj,
   output logic                      hit,
   output logic                      busy
);

   logic                   s1_v_ff, s1_v_in;
   logic                   s1_pos_ff, s1_pos_in;
   logic signed [DW:0]     s1_ax_ff, s1_ax_in;
   logic signed [DW:0]     s1_dy_ff, s1_dy_in;
   logic signed [DW:0]     s1_bx_ff, s1_bx_in;
   logic signed [DW:0]     s1_by_ff, s1_by_in;
   logic                   s2_v_ff, s2_pos_ff;
   logic signed [2*DW+1:0] s2_pa_ff, s2_pa_in;
   logic signed [2*DW+1:0] s2_pb_ff, s2_pb_in;
   logic                   hit_ff, hit_in;

   always_comb begin
      s1_v_in   = in_valid && ((yi > py) != (yj > py));
      s1_pos_in = yj > yi;
      s1_ax_in  = {px[DW-1], px} - {xi[DW-1], xi};
      s1_dy_in  = {yj[DW-1], yj} - {yi[DW-1], yi};
      s1_bx_in  = {xj[DW-1], xj} - {xi[DW-1], xi};
      s1_by_in  = {py[DW-1], py} - {yi[DW-1], yi};
      s2_pa_in  = s1_ax_ff * s1_dy_ff;
      s2_pb_in  = s1_bx_ff * s1_by_ff;
      hit_in    = s2_v_ff && (s2_pos_ff ? (s2_pa_ff < s2_pb_ff) : (s2_pa_ff > s2_pb_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s1_v_ff;
         hit_ff  <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_pos_ff <= s1_pos_in;
      s1_ax_ff  <= s1_ax_in;
      s1_dy_ff  <= s1_dy_in;
      s1_bx_ff  <= s1_bx_in;
      s1_by_ff  <= s1_by_in;
      s2_pos_ff <= s1_pos_ff;
      s2_pa_ff  <= s2_pa_in;
      s2_pb_ff  <= s2_pb_in;
   end

   assign hit  = hit_ff;
   assign busy = s1_v_ff || s2_v_ff || hit_ff;

endmodule

`default_nettype wire

// ===== rtl/core/point_in_polygon_test_top.sv =====
// ---------------------------------------------------------------------------
// Point-in-polygon test
// Keeps a polygon in a ring of vertex cells and answers even-odd
// crossing-number queries, one edge per cycle.
//
//   Channel  Direction  Transfer carries
//   req      in         kind, coord_x, coord_y
//   rsp      out        inside_res, crossing_count, table_overflowed
//
// Clear and append give no response. For a test, the ring rotates one
// vertex per cycle into the edge unit, whose three pipeline stages drain
// before the result is registered; an empty polygon skips the rotation.
// A finished result waits in the output register; a new request is taken
// while it waits, but a second test holds its result until the first is taken.
// Reset empties the polygon and clears the overflow flag.
// ---------------------------------------------------------------------------
`default_nettype none

module point_in_polygon_test_top #(
   parameter int MAX_VERTICES = 64,
   parameter int COORD_BITS   = 20
) (
   input  wire logic clock,
   input  wire logic reset,
   pip_req_if.sink   req,
   pip_rsp_if.source rsp
);

   import pip_pkg::*;

   localparam int DW = COORD_BITS;
   localparam int CW = $clog2(MAX_VERTICES + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_RUN   = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [CW-1:0]        total_ff, total_in;
   logic                 ovf_ff, ovf_in;
   logic [CW-1:0]        step_ff, step_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_inside_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_ovf_ff;
   logic signed [DW-1:0] px_ff, py_ff, prev_x_ff, prev_y_ff, last_x_ff, last_y_ff;
   logic signed [DW-1:0] cx [MAX_VERTICES];
   logic signed [DW-1:0] cy [MAX_VERTICES];
   logic                 accept, do_append, do_test, shift, done, hit, busy;

   assign accept    = req.valid && req.ready;
   assign do_append = accept && (req.kind == KIND_APPEND) && (total_ff < CW'(MAX_VERTICES));
   assign do_test   = accept && (req.kind == KIND_TEST);
   assign shift     = (state_ff == ST_RUN);
   assign done      = (state_ff == ST_DRAIN) && !busy && (!rsp_valid_ff || rsp.ready);

   for (genvar k = 0; k < MAX_VERTICES; k++) begin : g_cell
      logic signed [DW-1:0] src_x, src_y;
      if (k == MAX_VERTICES - 1) begin : g_end
         assign src_x = cx[0];
         assign src_y = cy[0];
      end else begin : g_mid
         assign src_x = (total_ff == CW'(k + 1)) ? cx[0] : cx[k+1];
         assign src_y = (total_ff == CW'(k + 1)) ? cy[0] : cy[k+1];
      end
      pip_cell #(.DW(DW)) u_cell (
         .clock    (clock),
         .load_en  (do_append && (total_ff == CW'(k))),
         .load_x   (req.coord_x),
         .load_y   (req.coord_y),
         .shift_en (shift),
         .next_x   (src_x),
         .next_y   (src_y),
         .cell_x   (cx[k]),
         .cell_y   (cy[k])
      );
   end

   pip_edge #(.DW(DW)) u_edge (
      .clock    (clock),
      .reset    (reset),
      .in_valid (shift),
      .px       (px_ff),
      .py       (py_ff),
      .xi       (cx[0]),
      .yi       (cy[0]),
      .xj       (prev_x_ff),
      .yj       (prev_y_ff),
      .hit      (hit),
      .busy     (busy)
   );

   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      ovf_in       = ovf_ff;
      step_in      = step_ff;
      count_in     = hit ? count_ff + CW'(1) : count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (accept && req.kind == KIND_CLEAR) begin
         total_in = '0;
         ovf_in   = 1'b0;
      end
      if (do_append) begin
         total_in = total_ff + CW'(1);
      end
      if (accept && req.kind == KIND_APPEND && !do_append) begin
         ovf_in = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (do_test) begin
               step_in  = '0;
               count_in = '0;
               state_in = (total_ff == '0) ? ST_DRAIN : ST_RUN;
            end
         end
         ST_RUN: begin
            step_in = step_ff + CW'(1);
            if (step_ff == total_ff - CW'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      count_ff <= count_in;
      if (do_append) begin
         last_x_ff <= req.coord_x;
         last_y_ff <= req.coord_y;
      end
      if (do_test) begin
         px_ff     <= req.coord_x;
         py_ff     <= req.coord_y;
         prev_x_ff <= last_x_ff;
         prev_y_ff <= last_y_ff;
      end else if (shift) begin
         prev_x_ff <= cx[0];
         prev_y_ff <= cy[0];
      end
      if (done) begin
         rsp_inside_ff <= count_ff[0];
         rsp_count_ff  <= COUNT_W'(count_ff);
         rsp_ovf_ff    <= ovf_ff;
      end
   end

   assign req.ready            = (state_ff == ST_IDLE);
   assign rsp.valid            = rsp_valid_ff;
   assign rsp.inside_res       = rsp_inside_ff;
   assign rsp.crossing_count   = rsp_count_ff;
   assign rsp.table_overflowed = rsp_ovf_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CW'(MAX_VERTICES))
      else $error("vertex total beyond capacity");

   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req.kind == KIND_CLEAR |=> total_ff == '0 && !ovf_ff)
      else $error("clear did not empty the polygon");

   a_run_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> total_ff != '0 && step_ff < total_ff)
      else $error("edge walk outside the stored polygon");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff && !(accept && req.kind == KIND_CLEAR) |=> ovf_ff)
      else $error("overflow flag lost without a clear");

endmodule

`default_nettype wire
